FILE: sv/ddp_pkg.sv
// shared types, codes and saturation helpers for the differential drive pid block
// no dependencies; compiled first
`default_nettype none

package ddp_pkg;

  localparam int SPEED_W   = 16;
  localparam int ERR_W     = 17;
  localparam int DERIV_W   = 18;
  localparam int INTEG_W   = 32;
  localparam int DRIVE_W   = 24;
  localparam int GAIN_W    = 17;
  localparam int TRACK_W   = 16;
  localparam int PROD_W    = 33;
  localparam int OPND_W    = 33;
  localparam int ACC_W     = 51;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 16;
  localparam int STEP_W    = 3;

  localparam int Q_DEPTH   = 2;
  localparam int Q_PTR_W   = 1;
  localparam int Q_CNT_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK = 8'd3;

  localparam logic MODE_MEAS = 1'b0;
  localparam logic MODE_CMD  = 1'b1;

  // multiplier schedule of the back end, left wheel then right wheel
  localparam logic [STEP_W-1:0] STEP_KP_L = 3'd0;
  localparam logic [STEP_W-1:0] STEP_KI_L = 3'd1;
  localparam logic [STEP_W-1:0] STEP_KD_L = 3'd2;
  localparam logic [STEP_W-1:0] STEP_KP_R = 3'd3;
  localparam logic [STEP_W-1:0] STEP_KI_R = 3'd4;
  localparam logic [STEP_W-1:0] STEP_KD_R = 3'd5;
  localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

  typedef struct packed {
    logic                      mode;
    logic signed [SPEED_W-1:0] left;
    logic signed [SPEED_W-1:0] right;
  } ddp_item_t;

  typedef struct packed {
    logic [GAIN_W-1:0] kp;
    logic [GAIN_W-1:0] ki;
    logic [GAIN_W-1:0] kd;
  } ddp_gains_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ddp_q_stat_t;

  typedef struct packed {
    logic idle;
    logic load;
  } ddp_back_stat_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_WRITE
  } ddp_state_t;

  function automatic logic signed [SPEED_W-1:0] sat16(input logic signed [33:0] x);
    if (x > 34'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -34'sd32768) begin
      return 16'sh8000;
    end
    return x[SPEED_W-1:0];
  endfunction

  function automatic logic signed [INTEG_W-1:0] sat32(input logic signed [32:0] x);
    if (x > 33'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (x < -33'sd2147483648) begin
      return 32'sh80000000;
    end
    return x[INTEG_W-1:0];
  endfunction

  function automatic logic signed [DRIVE_W-1:0] sat24(input logic signed [ACC_W-1:0] x);
    if (x > 51'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (x < -51'sd8388608) begin
      return 24'sh800000;
    end
    return x[DRIVE_W-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/ddp_queue.sv
// two-entry queue of classified wheel speed items between front and back end
// depends on ddp_pkg
`default_nettype none

module ddp_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire ddp_pkg::ddp_item_t   push_item,
  input  wire logic                 pop,
  output ddp_pkg::ddp_item_t        head,
  output ddp_pkg::ddp_q_stat_t      stat
);

  ddp_pkg::ddp_item_t                mem [ddp_pkg::Q_DEPTH];
  logic [ddp_pkg::Q_PTR_W-1:0]       wr_ptr;
  logic [ddp_pkg::Q_PTR_W-1:0]       rd_ptr;
  logic [ddp_pkg::Q_CNT_W-1:0]       count;
  logic                              do_push;
  logic                              do_pop;

  assign stat.full  = (count == ddp_pkg::Q_CNT_W'(ddp_pkg::Q_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ddp_front.sv
// front end: takes input transactions, turns body speeds into wheel speeds
// depends on ddp_pkg; feeds ddp_queue
`default_nettype none

module ddp_front #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                mode,
  input  wire logic signed [ddp_pkg::SPEED_W-1:0]  linear_speed,
  input  wire logic signed [ddp_pkg::SPEED_W-1:0]  turn_rate,
  input  wire logic [ddp_pkg::TRACK_W-1:0]         half_track,
  input  wire logic                                q_full,
  output logic                                     q_push,
  output ddp_pkg::ddp_item_t                       q_item,
  output logic                                     busy
);

  logic                                v1;
  logic                                mode1;
  logic signed [ddp_pkg::SPEED_W-1:0]  lin1;
  logic signed [ddp_pkg::SPEED_W-1:0]  turn1;
  logic                                v2;
  logic                                mode2;
  logic signed [ddp_pkg::SPEED_W-1:0]  lin2;
  logic signed [ddp_pkg::PROD_W-1:0]   prod2;

  logic                                accept;
  logic                                move1;
  logic signed [ddp_pkg::PROD_W-1:0]   turn_ext;
  logic signed [ddp_pkg::PROD_W-1:0]   track_ext;
  logic signed [ddp_pkg::PROD_W-1:0]   mul;
  logic signed [ddp_pkg::PROD_W-1:0]   delta;
  logic signed [33:0]                  left_w;
  logic signed [33:0]                  right_w;

  assign q_push   = v2 && !q_full;
  assign move1    = v1 && (!v2 || q_push);
  assign in_stall = v1 && !move1;
  assign accept   = in_valid && !in_stall;
  assign busy     = v1 || v2;

  assign turn_ext  = ddp_pkg::PROD_W'(turn1);
  assign track_ext = $signed({{(ddp_pkg::PROD_W-ddp_pkg::TRACK_W){1'b0}}, half_track});
  assign mul       = turn_ext * track_ext;

  // floor shift back to speed format
  assign delta   = prod2 >>> FRAC_BITS;
  assign left_w  = 34'(lin2) - 34'(delta);
  assign right_w = 34'(lin2) + 34'(delta);

  assign q_item.mode  = mode2;
  assign q_item.left  = ddp_pkg::sat16(left_w);
  assign q_item.right = ddp_pkg::sat16(right_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept) begin
        v1 <= 1'b1;
      end else if (move1) begin
        v1 <= 1'b0;
      end
      if (move1) begin
        v2 <= 1'b1;
      end else if (q_push) begin
        v2 <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode1 <= mode;
      lin1  <= linear_speed;
      turn1 <= turn_rate;
    end
    if (move1) begin
      mode2 <= mode1;
      lin2  <= lin1;
      prod2 <= mul;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ddp_back.sv
// back end: applies measurements and runs both pid loops on one shared multiplier
// depends on ddp_pkg; drains ddp_queue and owns the output register
`default_nettype none

module ddp_back #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire ddp_pkg::ddp_gains_t                 gains,
  input  wire ddp_pkg::ddp_q_stat_t                q_stat,
  input  wire ddp_pkg::ddp_item_t                  q_head,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [ddp_pkg::DRIVE_W-1:0]       left_drive,
  output logic signed [ddp_pkg::DRIVE_W-1:0]       right_drive,
  output ddp_pkg::ddp_back_stat_t                  stat
);

  ddp_pkg::ddp_state_t                 state;
  ddp_pkg::ddp_state_t                 state_next;
  logic [ddp_pkg::STEP_W-1:0]          step;
  logic [ddp_pkg::STEP_W-1:0]          step_next;

  logic signed [ddp_pkg::SPEED_W-1:0]  meas_left;
  logic signed [ddp_pkg::SPEED_W-1:0]  meas_right;
  logic signed [ddp_pkg::INTEG_W-1:0]  integ_left;
  logic signed [ddp_pkg::INTEG_W-1:0]  integ_right;
  logic signed [ddp_pkg::ERR_W-1:0]    last_err_left;
  logic signed [ddp_pkg::ERR_W-1:0]    last_err_right;
  logic signed [ddp_pkg::DERIV_W-1:0]  deriv_left;
  logic signed [ddp_pkg::DERIV_W-1:0]  deriv_right;

  logic signed [ddp_pkg::ACC_W-1:0]    prod;
  logic signed [ddp_pkg::ACC_W-1:0]    acc;
  logic signed [ddp_pkg::DRIVE_W-1:0]  hold_left;

  logic                                take_meas;
  logic                                take_cmd;
  logic                                load;
  logic signed [ddp_pkg::ERR_W-1:0]    err_l;
  logic signed [ddp_pkg::ERR_W-1:0]    err_r;
  logic signed [ddp_pkg::DERIV_W-1:0]  d_l;
  logic signed [ddp_pkg::DERIV_W-1:0]  d_r;
  logic signed [ddp_pkg::INTEG_W-1:0]  i_l;
  logic signed [ddp_pkg::INTEG_W-1:0]  i_r;
  logic [ddp_pkg::GAIN_W-1:0]          opnd_gain;
  logic signed [ddp_pkg::OPND_W-1:0]   opnd_val;
  logic signed [ddp_pkg::GAIN_W:0]     gain_s;
  logic signed [ddp_pkg::ACC_W-1:0]    acc_base;
  logic signed [ddp_pkg::ACC_W-1:0]    acc_shift;

  assign err_l = ddp_pkg::ERR_W'(q_head.left) - ddp_pkg::ERR_W'(meas_left);
  assign err_r = ddp_pkg::ERR_W'(q_head.right) - ddp_pkg::ERR_W'(meas_right);
  assign d_l   = ddp_pkg::DERIV_W'(err_l) - ddp_pkg::DERIV_W'(last_err_left);
  assign d_r   = ddp_pkg::DERIV_W'(err_r) - ddp_pkg::DERIV_W'(last_err_right);
  assign i_l   = ddp_pkg::sat32(33'(integ_left) + 33'(err_l));
  assign i_r   = ddp_pkg::sat32(33'(integ_right) + 33'(err_r));

  assign acc_shift = acc >>> FRAC_BITS;
  assign gain_s    = $signed({1'b0, opnd_gain});

  // after the pop, integ and last_err already hold this step's values
  always_comb begin
    opnd_gain = gains.kp;
    opnd_val  = ddp_pkg::OPND_W'(last_err_left);
    unique case (step)
      ddp_pkg::STEP_KP_L: begin
        opnd_gain = gains.kp;
        opnd_val  = ddp_pkg::OPND_W'(last_err_left);
      end
      ddp_pkg::STEP_KI_L: begin
        opnd_gain = gains.ki;
        opnd_val  = ddp_pkg::OPND_W'(integ_left);
      end
      ddp_pkg::STEP_KD_L: begin
        opnd_gain = gains.kd;
        opnd_val  = ddp_pkg::OPND_W'(deriv_left);
      end
      ddp_pkg::STEP_KP_R: begin
        opnd_gain = gains.kp;
        opnd_val  = ddp_pkg::OPND_W'(last_err_right);
      end
      ddp_pkg::STEP_KI_R: begin
        opnd_gain = gains.ki;
        opnd_val  = ddp_pkg::OPND_W'(integ_right);
      end
      ddp_pkg::STEP_KD_R: begin
        opnd_gain = gains.kd;
        opnd_val  = ddp_pkg::OPND_W'(deriv_right);
      end
      default: begin
        opnd_gain = '0;
        opnd_val  = '0;
      end
    endcase
  end

  // a new wheel sum starts from the first product of each wheel
  always_comb begin
    if (step == ddp_pkg::STEP_KI_L || step == ddp_pkg::STEP_KI_R) begin
      acc_base = '0;
    end else begin
      acc_base = acc;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    take_meas  = 1'b0;
    take_cmd   = 1'b0;
    load       = 1'b0;
    unique case (state)
      ddp_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          if (q_head.mode == ddp_pkg::MODE_CMD) begin
            take_cmd   = 1'b1;
            step_next  = ddp_pkg::STEP_KP_L;
            state_next = ddp_pkg::B_RUN;
          end else begin
            take_meas = 1'b1;
          end
        end
      end
      ddp_pkg::B_RUN: begin
        step_next = step + 1'b1;
        if (step == ddp_pkg::STEP_LAST) begin
          state_next = ddp_pkg::B_WRITE;
        end
      end
      ddp_pkg::B_WRITE: begin
        if (!out_valid || !out_stall) begin
          load       = 1'b1;
          state_next = ddp_pkg::B_IDLE;
        end
      end
      default: begin
        state_next = ddp_pkg::B_IDLE;
      end
    endcase
  end

  assign q_pop     = take_meas || take_cmd;
  assign stat.idle = (state == ddp_pkg::B_IDLE);
  assign stat.load = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ddp_pkg::B_IDLE;
      step           <= '0;
      out_valid      <= 1'b0;
      meas_left      <= '0;
      meas_right     <= '0;
      integ_left     <= '0;
      integ_right    <= '0;
      last_err_left  <= '0;
      last_err_right <= '0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= load || (out_valid && out_stall);
      if (take_meas) begin
        meas_left  <= q_head.left;
        meas_right <= q_head.right;
      end
      if (take_cmd) begin
        integ_left     <= i_l;
        integ_right    <= i_r;
        last_err_left  <= err_l;
        last_err_right <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_cmd) begin
      deriv_left  <= d_l;
      deriv_right <= d_r;
    end
    if (state == ddp_pkg::B_RUN) begin
      if (step <= ddp_pkg::STEP_KD_R) begin
        prod <= ddp_pkg::ACC_W'(gain_s) * ddp_pkg::ACC_W'(opnd_val);
      end
      if (step != ddp_pkg::STEP_KP_L) begin
        acc <= acc_base + prod;
      end
      if (step == ddp_pkg::STEP_KI_R) begin
        hold_left <= ddp_pkg::sat24(acc_shift);
      end
    end
    if (load) begin
      left_drive  <= hold_left;
      right_drive <= ddp_pkg::sat24(acc_shift);
    end
  end

endmodule

`default_nettype wire

FILE: sv/diff_drive_dual_pid.sv
// top level of the differential drive wheel speed controller with two pid loops
// holds the configuration registers; depends on ddp_pkg, ddp_front, ddp_queue, ddp_back
//
//   channel   handshake            payload
//   input     in_valid / in_stall  mode, linear_speed, turn_rate
//   output    out_valid/ out_stall left_drive, right_drive
//   config    cfg_write            cfg_index, cfg_data
//
// front end takes one transaction every cycle while the queue has room.
// back end: a measurement is taken straight from idle; a command runs the six products
// on the one shared multiplier between its pop and the output load.
// rst is synchronous; there is no clearing pass.
// the output register lets the back end pop the next item while a result is stalled.
`default_nettype none

module diff_drive_dual_pid #(
  parameter int FRAC_BITS = 12
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  mode,
  input  wire logic signed [ddp_pkg::SPEED_W-1:0]    linear_speed,
  input  wire logic signed [ddp_pkg::SPEED_W-1:0]    turn_rate,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [ddp_pkg::DRIVE_W-1:0]         left_drive,
  output logic signed [ddp_pkg::DRIVE_W-1:0]         right_drive,
  input  wire logic                                  cfg_write,
  input  wire logic [ddp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [ddp_pkg::CFG_DAT_W-1:0]         cfg_data
);

  localparam logic [ddp_pkg::GAIN_W-1:0]  KP_RESET = ddp_pkg::GAIN_W'(1 << FRAC_BITS);
  localparam logic [ddp_pkg::GAIN_W-1:0]  KI_RESET =
    ddp_pkg::GAIN_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [ddp_pkg::GAIN_W-1:0]  KD_RESET =
    ddp_pkg::GAIN_W'(((1 << FRAC_BITS) + 10) / 20);
  localparam logic [ddp_pkg::TRACK_W-1:0] HT_RESET = ddp_pkg::TRACK_W'((1 << FRAC_BITS) / 4);

  ddp_pkg::ddp_gains_t             gains;
  logic [ddp_pkg::TRACK_W-1:0]     half_track;
  ddp_pkg::ddp_item_t              f_item;
  ddp_pkg::ddp_item_t              q_head;
  ddp_pkg::ddp_q_stat_t            q_stat;
  ddp_pkg::ddp_back_stat_t         b_stat;
  logic                            q_push;
  logic                            q_pop;
  logic                            f_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains.kp   <= KP_RESET;
      gains.ki   <= KI_RESET;
      gains.kd   <= KD_RESET;
      half_track <= HT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ddp_pkg::REG_GAIN_PROP:  gains.kp   <= {1'b0, cfg_data};
        ddp_pkg::REG_GAIN_INTEG: gains.ki   <= {1'b0, cfg_data};
        ddp_pkg::REG_GAIN_DERIV: gains.kd   <= {1'b0, cfg_data};
        ddp_pkg::REG_HALF_TRACK: half_track <= cfg_data;
        default: ;
      endcase
    end
  end

  ddp_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .linear_speed (linear_speed),
    .turn_rate    (turn_rate),
    .half_track   (half_track),
    .q_full       (q_stat.full),
    .q_push       (q_push),
    .q_item       (f_item),
    .busy         (f_busy)
  );

  ddp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (f_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  ddp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .gains       (gains),
    .q_stat      (q_stat),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_drive  (left_drive),
    .right_drive (right_drive),
    .stat        (b_stat)
  );

`ifndef SYNTHESIS
  a_queue_stat: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty at once");

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(b_stat.load))
    else $error("result appeared without an output load");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> f_busy)
    else $error("accepted transaction not held by the front end");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (b_stat.idle && !q_stat.empty))
    else $error("queue popped outside idle or while empty");
`endif

endmodule

`default_nettype wire
